/* sv/color_mask_bottom_edge_finder_defines.svh */
// Assertion macros of the color mask bottom edge finder.
`ifndef COLOR_MASK_BOTTOM_EDGE_FINDER_DEFINES_SVH
`define COLOR_MASK_BOTTOM_EDGE_FINDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checks a property on every rising edge of clk, skipped while rst is high.
`define CMBEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a condition never holds on a rising edge of clk.
`define CMBEF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CMBEF_ASSERT(lbl, prop, msg)
`define CMBEF_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* sv/cmbef_pkg.sv */
// Shared constants and types of the color mask bottom edge finder.
package cmbef_pkg;

  // Frame side in pixels and the width of one stored column entry at that size.
  localparam int SIDE_DEFAULT    = 512;
  localparam int ENTRY_W_DEFAULT = 10;

  // Field widths.
  localparam int HSV_W      = 8;
  localparam int ROW_CFG_W  = 9;
  localparam int COL_IN_W   = 9;
  localparam int EDGE_ROW_W = 9;

  // Stream widths.
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_HUE_LOW          = 3'd0,
    REG_HUE_HIGH         = 3'd1,
    REG_SAT_LOW          = 3'd2,
    REG_VAL_LOW          = 3'd3,
    REG_SKY_END_ROW      = 3'd4,
    REG_WHEELS_START_ROW = 3'd5,
    REG_BUMPER_START_ROW = 3'd6
  } reg_idx_t;

  // Register reset values.
  localparam logic [HSV_W-1:0]     HUE_LOW_RST          = 8'd5;
  localparam logic [HSV_W-1:0]     HUE_HIGH_RST         = 8'd15;
  localparam logic [HSV_W-1:0]     SAT_LOW_RST          = 8'd140;
  localparam logic [HSV_W-1:0]     VAL_LOW_RST          = 8'd140;
  localparam logic [ROW_CFG_W-1:0] SKY_END_ROW_RST      = 9'd0;
  localparam logic [ROW_CFG_W-1:0] WHEELS_START_ROW_RST = 9'd511;
  localparam logic [ROW_CFG_W-1:0] BUMPER_START_ROW_RST = 9'd511;

endpackage

/* sv/cmbef_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module cmbef_ram #(
  parameter int WIDTH = cmbef_pkg::ENTRY_W_DEFAULT,
  parameter int DEPTH = cmbef_pkg::SIDE_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import cmbef_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/color_mask_bottom_edge_finder.sv */
// Color mask bottom edge finder: HSV pixel thresholding with per-column lowest-mark store.
//
// The block takes HSV pixels of a SIDE x SIDE frame in raster order and marks each pixel
// whose hue lies in [hue_low, hue_high] and whose saturation and value reach sat_low and
// val_low, unless it falls in the sky band, the wheels band or the bumper band (center
// third of the columns). Every item returns one result: a pixel item returns its mark bit,
// a readout item returns the lowest marked row of the chosen column with a found flag and
// then empties that column. The block sustains one item per clock cycle while the output is
// not held by back-pressure; a result passes through the input register and the result
// register. Each item reads the column store, a RAM, once and writes it at most once: the
// read is issued as the item is accepted, the update is written as the item leaves the input
// register, and a forwarding register covers an item that reads the entry written in the
// same cycle. After reset the store is cleared one entry per cycle, and no item is accepted
// during that pass; configuration writes are taken at any time but should only be made while
// no item is in flight.
`include "color_mask_bottom_edge_finder_defines.svh"

module color_mask_bottom_edge_finder #(
  parameter int SIDE = cmbef_pkg::SIDE_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Pixel and readout items.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // hue [7:0], saturation [15:8], brightness [23:16], read_column [32:24]
  input  logic [cmbef_pkg::S_TDATA_W-1:0] s_tdata,
  // kind [0], frame_start [1]
  input  logic [cmbef_pkg::S_TUSER_W-1:0] s_tuser,
  // Results.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // mask_bit [0], edge_found [1], edge_row [10:2]
  output logic [cmbef_pkg::M_TDATA_W-1:0] m_tdata,
  // Configuration registers.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmbef_pkg::CFG_AW-1:0]    paddr,
  input  logic [cmbef_pkg::CFG_DW-1:0]    pwdata,
  output logic [cmbef_pkg::CFG_DW-1:0]    prdata,
  output logic                            pready
);
  import cmbef_pkg::*;

  // Position width, a comparison width that holds both positions and row settings,
  // and the width of one store entry (valid flag above the row).
  localparam int AW      = $clog2(SIDE);
  localparam int LW      = ($clog2(SIDE + 1) > ROW_CFG_W) ? $clog2(SIDE + 1) : ROW_CFG_W;
  localparam int ENTRY_W = AW + 1;

  localparam logic [AW-1:0] LAST_POS = AW'(SIDE - 1);
  localparam logic [AW-1:0] BUMP_LO  = AW'(SIDE / 3);
  localparam logic [AW-1:0] BUMP_HI  = AW'(2 * SIDE / 3);
  localparam logic [LW-1:0] SIDE_L   = LW'(SIDE);

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [HSV_W-1:0]     hue_low;
  logic [HSV_W-1:0]     hue_high;
  logic [HSV_W-1:0]     sat_low;
  logic [HSV_W-1:0]     val_low;
  logic [ROW_CFG_W-1:0] sky_end_row;
  logic [ROW_CFG_W-1:0] wheels_start_row;
  logic [ROW_CFG_W-1:0] bumper_start_row;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_low          <= HUE_LOW_RST;
      hue_high         <= HUE_HIGH_RST;
      sat_low          <= SAT_LOW_RST;
      val_low          <= VAL_LOW_RST;
      sky_end_row      <= SKY_END_ROW_RST;
      wheels_start_row <= WHEELS_START_ROW_RST;
      bumper_start_row <= BUMPER_START_ROW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HUE_LOW:          hue_low          <= pwdata[HSV_W-1:0];
        REG_HUE_HIGH:         hue_high         <= pwdata[HSV_W-1:0];
        REG_SAT_LOW:          sat_low          <= pwdata[HSV_W-1:0];
        REG_VAL_LOW:          val_low          <= pwdata[HSV_W-1:0];
        REG_SKY_END_ROW:      sky_end_row      <= pwdata[ROW_CFG_W-1:0];
        REG_WHEELS_START_ROW: wheels_start_row <= pwdata[ROW_CFG_W-1:0];
        REG_BUMPER_START_ROW: bumper_start_row <= pwdata[ROW_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HUE_LOW:          prdata = CFG_DW'(hue_low);
      REG_HUE_HIGH:         prdata = CFG_DW'(hue_high);
      REG_SAT_LOW:          prdata = CFG_DW'(sat_low);
      REG_VAL_LOW:          prdata = CFG_DW'(val_low);
      REG_SKY_END_ROW:      prdata = CFG_DW'(sky_end_row);
      REG_WHEELS_START_ROW: prdata = CFG_DW'(wheels_start_row);
      REG_BUMPER_START_ROW: prdata = CFG_DW'(bumper_start_row);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Input unpacking and frame position
  // ---------------------------------------------------------------------------------------
  logic                 in_kind;
  logic                 in_frame_start;
  logic [HSV_W-1:0]     in_hue;
  logic [HSV_W-1:0]     in_sat;
  logic [HSV_W-1:0]     in_bri;
  logic [COL_IN_W-1:0]  in_read_column;
  logic                 accept;
  logic                 out_free;
  logic                 clearing;

  assign in_kind        = s_tuser[0];
  assign in_frame_start = s_tuser[1];
  assign in_hue         = s_tdata[7:0];
  assign in_sat         = s_tdata[15:8];
  assign in_bri         = s_tdata[23:16];
  assign in_read_column = s_tdata[32:24];

  logic [AW-1:0] row_pos;
  logic [AW-1:0] col_pos;
  logic [AW-1:0] row_eff;
  logic [AW-1:0] col_eff;

  // A frame start puts this pixel at row zero, column zero.
  assign row_eff = in_frame_start ? '0 : row_pos;
  assign col_eff = in_frame_start ? '0 : col_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept && !in_kind) begin
      if (col_eff == LAST_POS) begin
        col_pos <= '0;
        row_pos <= (row_eff == LAST_POS) ? '0 : row_eff + AW'(1);
      end else begin
        col_pos <= col_eff + AW'(1);
        row_pos <= row_eff;
      end
    end
  end

  // Readout column, checked against the frame width; the check does not gate the read.
  logic [LW-1:0] rc_ext;
  logic          rc_in_range;
  logic [AW-1:0] rd_addr;

  assign rc_ext      = LW'(in_read_column);
  assign rc_in_range = rc_ext < SIDE_L;
  assign rd_addr     = in_kind ? rc_ext[AW-1:0] : col_eff;

  // ---------------------------------------------------------------------------------------
  // Input register: the accepted item waits here while its store entry is read.
  // ---------------------------------------------------------------------------------------
  logic             s1_valid;
  logic             s1_kind;
  logic             s1_in_range;
  logic [AW-1:0]    s1_addr;
  logic [AW-1:0]    s1_row;
  logic [HSV_W-1:0] s1_hue;
  logic [HSV_W-1:0] s1_sat;
  logic [HSV_W-1:0] s1_bri;
  logic             adv1;

  assign out_free = !m_tvalid || m_tready;
  assign adv1     = s1_valid && out_free;
  assign s_tready = !clearing && (!s1_valid || out_free);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv1) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind     <= in_kind;
      s1_in_range <= rc_in_range;
      s1_addr     <= rd_addr;
      s1_row      <= row_eff;
      s1_hue      <= in_hue;
      s1_sat      <= in_sat;
      s1_bri      <= in_bri;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Column store and its clearing pass
  // ---------------------------------------------------------------------------------------
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [AW-1:0]      clr_addr;
  logic               s1_we;
  logic [ENTRY_W-1:0] s1_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_POS) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_we;
      ram_waddr = s1_addr;
      ram_wdata = s1_wdata;
    end
  end

  cmbef_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SIDE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // The write that lands in the same cycle as an item's read is not seen by that read,
  // so it is kept here and used in its place when the addresses match.
  logic               fwd_valid;
  logic [AW-1:0]      fwd_addr;
  logic [ENTRY_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (accept) begin
      fwd_valid <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_addr <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Mark decision and store update
  // ---------------------------------------------------------------------------------------
  logic [ENTRY_W-1:0] stored;
  logic               st_valid;
  logic [AW-1:0]      st_row;
  logic [LW-1:0]      st_row_l;
  logic [LW-1:0]      row_l;
  logic               color_ok;
  logic               blanked;
  logic               pix_mark;
  logic               upd;
  logic               clr;

  assign stored   = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : ram_rdata;
  assign st_valid = stored[AW];
  assign st_row   = stored[AW-1:0];
  assign st_row_l = LW'(st_row);
  assign row_l    = LW'(s1_row);

  assign color_ok = (s1_hue >= hue_low) && (s1_hue <= hue_high) &&
                    (s1_sat >= sat_low) && (s1_bri >= val_low);

  assign blanked  = (row_l <= LW'(sky_end_row)) ||
                    (row_l >= LW'(wheels_start_row)) ||
                    ((row_l >= LW'(bumper_start_row)) &&
                     (s1_addr >= BUMP_LO) && (s1_addr <= BUMP_HI));

  assign pix_mark = color_ok && !blanked;

  // A mark replaces the stored row when the column is empty or the mark is at or below it.
  assign upd      = !s1_kind && pix_mark && (!st_valid || (s1_row >= st_row));
  // A readout of a column inside the frame empties it.
  assign clr      = s1_kind && s1_in_range;

  assign s1_we    = adv1 && (upd || clr);
  assign s1_wdata = upd ? {1'b1, s1_row} : '0;

  // ---------------------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------------------
  logic                  res_mask;
  logic                  res_found;
  logic [EDGE_ROW_W-1:0] res_row;

  assign res_mask  = !s1_kind && pix_mark;
  assign res_found = s1_kind && s1_in_range && st_valid;
  assign res_row   = res_found ? st_row_l[EDGE_ROW_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      m_tdata <= M_TDATA_W'({res_row, res_found, res_mask});
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  `CMBEF_ASSERT(a_no_accept_while_clearing, clearing |-> !s_tready, "item taken during clear")
  `CMBEF_ASSERT(a_idle_while_clearing, clearing |-> !s1_valid, "item in flight during clear")
  `CMBEF_ASSERT(a_accept_loads_stage, accept |=> s1_valid, "accepted item lost")
  `CMBEF_ASSERT_NEVER(a_mask_and_found, m_tvalid && m_tdata[0] && m_tdata[1],
    "result has both mark and found flag")

endmodule
